FILE: rtl/core/fpa_pkg.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Shared widths, operation codes and the pipeline side-band record.
// ----------------------------------------------------------------------------
package fpa_pkg;

  // Word and fraction widths of the Q24.8 format.
  localparam int WORD_BITS  = 32;
  localparam int FRAC_BITS  = 8;
  // Dividend width once shifted up by the fraction bits.
  localparam int NUM_BITS   = WORD_BITS + FRAC_BITS;
  // Quotient bits produced in each divider stage.
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = (NUM_BITS + DIV_STEPS - 1) / DIV_STEPS;
  // Widths of the multiply product and its rounded magnitude.
  localparam int PROD_BITS  = 2 * WORD_BITS;
  localparam int MAG_BITS   = PROD_BITS + 1 - FRAC_BITS;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_DIV  = 4'd3,
    OP_GT   = 4'd4,
    OP_LT   = 4'd5,
    OP_GE   = 4'd6,
    OP_LE   = 4'd7,
    OP_EQ   = 4'd8,
    OP_NE   = 4'd9,
    OP_MIN  = 4'd10,
    OP_MAX  = 4'd11,
    OP_INC  = 4'd12,
    OP_DEC  = 4'd13,
    OP_ITOF = 4'd14,
    OP_FTOI = 4'd15
  } op_t;

  // Side-band data that travels alongside the divider stages.
  typedef struct packed {
    op_t                        op;
    logic signed [WORD_BITS-1:0] res;
    logic                       flag;
    logic                       dz;
    logic                       neg;
    logic [PROD_BITS-1:0]       mag;
  } side_t;

endpackage

FILE: rtl/core/fpa_div_core.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Unsigned divide of a NUM_BITS dividend by a WORD_BITS divisor, two quotient
// bits per register stage, with a round-half-up indication at the end.
// ----------------------------------------------------------------------------
module fpa_div_core
  import fpa_pkg::*;
(
  input  logic                 clk,
  input  logic                 en,
  input  logic [NUM_BITS-1:0]  num_i,
  input  logic [WORD_BITS-1:0] den_i,
  output logic [NUM_BITS-1:0]  quo_o,
  output logic                 round_o
);

  // Stage registers; index 0 holds the unregistered inputs.
  logic [NUM_BITS-1:0]  n_w [0:DIV_STAGES];
  logic [WORD_BITS-1:0] d_w [0:DIV_STAGES];
  logic [WORD_BITS-1:0] r_w [0:DIV_STAGES];
  logic [NUM_BITS-1:0]  q_w [0:DIV_STAGES];

  assign n_w[0] = num_i;
  assign d_w[0] = den_i;
  assign r_w[0] = '0;
  assign q_w[0] = '0;

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [NUM_BITS-1:0]  n_nxt;
    logic [WORD_BITS-1:0] r_nxt;
    logic [NUM_BITS-1:0]  q_nxt;
    logic [NUM_BITS-1:0]  n_r;
    logic [WORD_BITS-1:0] d_r;
    logic [WORD_BITS-1:0] r_r;
    logic [NUM_BITS-1:0]  q_r;

    // Shift in one dividend bit per step and subtract when it fits.
    always_comb begin
      logic [WORD_BITS:0] r2;
      logic               fit;
      n_nxt = n_w[k];
      r_nxt = r_w[k];
      q_nxt = q_w[k];
      for (int s = 0; s < DIV_STEPS; s++) begin
        r2    = {r_nxt, n_nxt[NUM_BITS-1]};
        fit   = (r2 >= {1'b0, d_w[k]});
        r_nxt = fit ? WORD_BITS'(r2 - {1'b0, d_w[k]}) : r2[WORD_BITS-1:0];
        n_nxt = {n_nxt[NUM_BITS-2:0], 1'b0};
        q_nxt = {q_nxt[NUM_BITS-2:0], fit};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r <= n_nxt;
        d_r <= d_w[k];
        r_r <= r_nxt;
        q_r <= q_nxt;
      end
    end

    assign n_w[k+1] = n_r;
    assign d_w[k+1] = d_r;
    assign r_w[k+1] = r_r;
    assign q_w[k+1] = q_r;
  end

  // Round up when twice the remainder reaches the divisor.
  assign quo_o   = q_w[DIV_STAGES];
  assign round_o = ({r_w[DIV_STAGES], 1'b0} >= {1'b0, d_w[DIV_STAGES]});

endmodule

FILE: rtl/core/fixed_point_q24_8_alu.sv
// ----------------------------------------------------------------------------
// Signed Q24.8 fixed-point ALU
// Pipelined arithmetic, compare and conversion unit on 32-bit raw words.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries an operation code and two
//   raw Q24.8 operands. The result channel (out_valid/out_ready) returns one
//   transaction per input: the value and the compare, divide-by-zero and
//   saturation flags. Transactions leave in the order they arrived.
//   Each transaction passes the input register, then 20 divider stages at two
//   quotient bits each and then the output register, with rounding and
//   saturation in front of it.
//   All operations take the same path.
//   Throughput is one transaction per cycle while out_ready stays high.
//   When the receiver stalls, the whole pipeline holds and in_ready drops in
//   the same cycle; nothing is lost or repeated.
//   Reset clears all valid bits; no other register is reset.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu
  import fpa_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [3:0]                  in_operation,
  input  logic signed [WORD_BITS-1:0] in_operand_a,
  input  logic signed [WORD_BITS-1:0] in_operand_b,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [WORD_BITS-1:0] out_result_value,
  output logic                        out_compare_flag,
  output logic                        out_divide_by_zero,
  output logic                        out_saturated
);

  localparam logic [PROD_BITS-1:0] HALF  = PROD_BITS'(1) << (FRAC_BITS - 1);
  localparam logic [PROD_BITS-1:0] LIM_P = (PROD_BITS'(1) << (WORD_BITS - 1)) - 1;
  localparam logic [PROD_BITS-1:0] LIM_N = PROD_BITS'(1) << (WORD_BITS - 1);

  // Global advance: the pipeline moves when the output slot is free or taken.
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Valid bits: index 0 is the input stage, DIV_STAGES the last divider stage.
  logic [DIV_STAGES:0] v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[DIV_STAGES-1:0], in_valid};
    end
  end

  // Input stage: operands and their magnitudes.
  op_t                         op0_r;
  logic signed [WORD_BITS-1:0] a0_r;
  logic signed [WORD_BITS-1:0] b0_r;
  logic [WORD_BITS-1:0]        ma0_r;
  logic [WORD_BITS-1:0]        mb0_r;

  always_ff @(posedge clk) begin
    if (en) begin
      op0_r <= op_t'(in_operation);
      a0_r  <= in_operand_a;
      b0_r  <= in_operand_b;
      ma0_r <= in_operand_a[WORD_BITS-1] ? WORD_BITS'(-in_operand_a) : in_operand_a;
      mb0_r <= in_operand_b[WORD_BITS-1] ? WORD_BITS'(-in_operand_b) : in_operand_b;
    end
  end

  // Divider runs on every transaction; only divides use its output.
  logic [NUM_BITS-1:0] quo;
  logic                rnd_up;

  fpa_div_core u_div (
    .clk     (clk),
    .en      (en),
    .num_i   ({ma0_r, FRAC_BITS'(0)}),
    .den_i   (mb0_r),
    .quo_o   (quo),
    .round_o (rnd_up)
  );

  // Stage 1: simple results, flags and the raw product.
  side_t side_r [1:DIV_STAGES];
  side_t s1_nxt;

  always_comb begin
    s1_nxt      = '0;
    s1_nxt.op   = op0_r;
    s1_nxt.neg  = a0_r[WORD_BITS-1] ^ b0_r[WORD_BITS-1];
    s1_nxt.mag  = PROD_BITS'(ma0_r) * PROD_BITS'(mb0_r);
    case (op0_r)
      OP_ADD:  s1_nxt.res = a0_r + b0_r;
      OP_SUB:  s1_nxt.res = a0_r - b0_r;
      OP_DIV: begin
        s1_nxt.dz  = (b0_r == '0);
        s1_nxt.res = a0_r[WORD_BITS-1] ? LIM_N[WORD_BITS-1:0] : LIM_P[WORD_BITS-1:0];
      end
      OP_GT:   s1_nxt.flag = (a0_r > b0_r);
      OP_LT:   s1_nxt.flag = (a0_r < b0_r);
      OP_GE:   s1_nxt.flag = (a0_r >= b0_r);
      OP_LE:   s1_nxt.flag = (a0_r <= b0_r);
      OP_EQ:   s1_nxt.flag = (a0_r == b0_r);
      OP_NE:   s1_nxt.flag = (a0_r != b0_r);
      OP_MIN:  s1_nxt.res = (a0_r < b0_r) ? a0_r : b0_r;
      OP_MAX:  s1_nxt.res = (b0_r < a0_r) ? a0_r : b0_r;
      OP_INC:  s1_nxt.res = a0_r + WORD_BITS'(1);
      OP_DEC:  s1_nxt.res = a0_r - WORD_BITS'(1);
      OP_ITOF: s1_nxt.res = a0_r <<< FRAC_BITS;
      OP_FTOI: s1_nxt.res = a0_r >>> FRAC_BITS;
      default: s1_nxt.res = '0;
    endcase
  end

  // Stage 2 rounds the product half away from zero; later stages only delay.
  side_t         s2_nxt;
  logic [PROD_BITS:0] prod_rnd;

  always_comb begin
    s2_nxt   = side_r[1];
    prod_rnd = {1'b0, side_r[1].mag} + {1'b0, HALF};
    s2_nxt.mag = PROD_BITS'(prod_rnd >> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[1] <= s1_nxt;
      side_r[2] <= s2_nxt;
      for (int k = 3; k <= DIV_STAGES; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // Final stage: pick the magnitude, saturate and apply the sign.
  side_t                  sl;
  logic [PROD_BITS-1:0]   mag;
  logic [PROD_BITS-1:0]   lim;
  logic                   clamp;
  logic [WORD_BITS-1:0]   mag_w;
  logic signed [WORD_BITS-1:0] res_nxt;
  logic                   flag_nxt;
  logic                   dz_nxt;
  logic                   sat_nxt;

  always_comb begin
    sl       = side_r[DIV_STAGES];
    mag      = (sl.op == OP_DIV) ? PROD_BITS'(quo) + PROD_BITS'(rnd_up) : sl.mag;
    lim      = sl.neg ? LIM_N : LIM_P;
    clamp    = (mag > lim);
    mag_w    = clamp ? lim[WORD_BITS-1:0] : mag[WORD_BITS-1:0];
    res_nxt  = sl.res;
    flag_nxt = sl.flag;
    dz_nxt   = sl.dz;
    sat_nxt  = 1'b0;
    case (sl.op)
      OP_MUL: begin
        res_nxt = sl.neg ? WORD_BITS'(-mag_w) : mag_w;
        sat_nxt = clamp;
      end
      OP_DIV: begin
        if (sl.dz) begin
          sat_nxt = 1'b1;
        end else begin
          res_nxt = sl.neg ? WORD_BITS'(-mag_w) : mag_w;
          sat_nxt = clamp;
        end
      end
      default: sat_nxt = 1'b0;
    endcase
  end

  // Output register.
  logic                        out_valid_r;
  logic signed [WORD_BITS-1:0] res_r;
  logic                        flag_r;
  logic                        dz_r;
  logic                        sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v_r[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r  <= res_nxt;
      flag_r <= flag_nxt;
      dz_r   <= dz_nxt;
      sat_r  <= sat_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_value   = res_r;
  assign out_compare_flag   = flag_r;
  assign out_divide_by_zero = dz_r;
  assign out_saturated      = sat_r;

endmodule
